[rtl/core/arx_512bit_permutation_defines.svh]
// Assertion macros shared by the f512 permutation RTL.
`ifndef ARX_512BIT_PERMUTATION_DEFINES_SVH
`define ARX_512BIT_PERMUTATION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ARX_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ARX_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[rtl/core/arx512_pkg.sv]
// Package with types, constants and mixing functions of the f512 permutation.
`timescale 1ns / 1ps

package arx512_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int IDX_W      = $clog2(NUM_WORDS);
    localparam int ROUND_W    = 5;
    localparam logic [ROUND_W-1:0] MAX_ROUNDS = 5'd16;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_MIX,
        S_EMIT
    } t_state;

    // Round constants, one per round.
    localparam logic [7:0] ROUND_CONST [NUM_WORDS] = '{
        8'hEF, 8'hE0, 8'hD9, 8'hD6, 8'hBA, 8'hB5, 8'h8C, 8'h83,
        8'h10, 8'h1F, 8'h26, 8'h29, 8'h45, 8'h4A, 8'h73, 8'h7C
    };

    // First diffusion: x ^ rotr(x, 7) ^ rotr(x, 8).
    function automatic logic [WORD_W-1:0] diff_a(input logic [WORD_W-1:0] x);
        return x ^ {x[6:0], x[31:7]} ^ {x[7:0], x[31:8]};
    endfunction

    // Second diffusion: x ^ rotr(x, 15) ^ rotr(x, 23).
    function automatic logic [WORD_W-1:0] diff_b(input logic [WORD_W-1:0] x);
        return x ^ {x[14:0], x[31:15]} ^ {x[22:0], x[31:23]};
    endfunction

endpackage

[rtl/core/arx_512bit_permutation.sv]
// Top level of the f512 add-rotate-xor permutation with a word-serial interface.
// A word without the last mark is taken whenever the block is idle. A last word keeps
// o_busy high through the load state, which fills the running words, then R rounds of
// sixteen mix steps (R = clamped round count), one per cycle in the shared mixing unit,
// and sixteen result transfers back to back. Results cannot be stalled.
// Reset (synchronous, active low) clears the sequencer and the load index only.
`timescale 1ns / 1ps

`include "arx_512bit_permutation_defines.svh"

module arx_512bit_permutation
    import arx512_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [WORD_W-1:0]   i_state_word,
    input  logic [7:0]          i_domain,
    input  logic [ROUND_W-1:0]  i_round_count,
    input  logic                i_is_last,
    output logic                o_valid,
    output logic [WORD_W-1:0]   o_out_word,
    output logic                o_out_last
);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_load_idx;
    logic [IDX_W-1:0]     r_step;
    logic [IDX_W-1:0]     r_round;
    logic [ROUND_W-1:0]   r_rounds;
    logic [7:0]           r_domain;
    logic [WORD_W-1:0]    r_store [NUM_WORDS];
    logic [WORD_W-1:0]    r_run   [4];

    logic                 accept;
    logic                 last_step;
    logic                 last_round;
    logic [WORD_W-1:0]    eff0, eff1;
    logic [WORD_W-1:0]    t_sum1, t_mid, t_sum2, t_new;

    assign accept     = i_start && (r_state == S_IDLE);
    assign last_step  = (r_step == IDX_W'(NUM_WORDS - 1));
    assign last_round = ({1'b0, r_round} == (r_rounds - ROUND_W'(1)));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_is_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (r_rounds == '0) ? S_EMIT : S_MIX;
            end
            S_MIX: begin
                if (last_step && last_round) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (last_step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        o_busy     = 1'b1;
        o_valid    = 1'b0;
        o_out_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
            end
            S_EMIT: begin
                o_valid    = 1'b1;
                o_out_last = last_step;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    assign o_out_word = r_store[0];

    // Shared mixing unit. The running words rotate each step so that the
    // word slots a, b, c, d always sit at positions 0, 1, 2, 3. At the first
    // step of a round the constant and the domain byte enter slots 0 and 1.
    always_comb begin
        eff0 = r_run[0];
        eff1 = r_run[1];
        if (r_step == '0) begin
            eff0 = r_run[0] ^ {{(WORD_W-8){1'b0}}, ROUND_CONST[r_round]};
            eff1 = r_run[1] ^ {{(WORD_W-8){1'b0}}, r_domain};
        end
        t_sum1 = eff0 + r_run[3];
        t_mid  = diff_a(t_sum1) ^ r_run[2];
        t_sum2 = t_mid + r_store[2];
        t_new  = diff_b(t_sum2) ^ eff1;
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_idx <= '0;
            r_step     <= '0;
            r_round    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_load_idx <= i_is_last ? '0 : r_load_idx + IDX_W'(1);
            end
            case (r_state)
                S_LOAD: begin
                    r_step  <= '0;
                    r_round <= '0;
                end
                S_MIX: begin
                    r_step <= r_step + IDX_W'(1);
                    if (last_step) begin
                        r_round <= r_round + IDX_W'(1);
                    end
                end
                S_EMIT: begin
                    r_step <= r_step + IDX_W'(1);
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    // Captured permutation settings; the round count is clamped to the table.
    always_ff @(posedge i_clk) begin
        if (accept && i_is_last) begin
            r_domain <= i_domain;
            r_rounds <= (i_round_count > MAX_ROUNDS) ? MAX_ROUNDS : i_round_count;
        end
    end

    // State store: indexed write as words are accepted, full rotation while mixing and emitting.
    // Sixteen steps per round and sixteen emit shifts keep word 0 at the head.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_store[r_load_idx] <= i_state_word;
                end
            end
            S_MIX: begin
                for (int i = 0; i < NUM_WORDS - 1; i++) begin
                    r_store[i] <= r_store[i+1];
                end
                r_store[NUM_WORDS-1] <= t_new;
            end
            S_EMIT: begin
                for (int i = 0; i < NUM_WORDS - 1; i++) begin
                    r_store[i] <= r_store[i+1];
                end
                r_store[NUM_WORDS-1] <= r_store[0];
            end
            default: begin
                r_store[0] <= r_store[0];
            end
        endcase
    end

    // Running words: loaded from words 0, 1, 14, 15, then rotated each step.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_run[0] <= r_store[0];
                r_run[1] <= r_store[1];
                r_run[2] <= r_store[NUM_WORDS-2];
                r_run[3] <= r_store[NUM_WORDS-1];
            end
            S_MIX: begin
                r_run[0] <= eff1;
                r_run[1] <= r_store[2];
                r_run[2] <= r_run[3];
                r_run[3] <= t_new;
            end
            default: begin
                r_run[0] <= r_run[0];
            end
        endcase
    end

    // A result transfer only happens while the block reports busy.
    `ARX_ASSERT_SAME(a_valid_busy, o_valid, o_busy, "result strobe while idle")
    // The last mark comes only with a result transfer.
    `ARX_ASSERT_SAME(a_last_valid, o_out_last, o_valid, "last mark without strobe")
    // A last word always starts the permutation in the next cycle.
    `ARX_ASSERT_NEXT(a_last_load, i_start && !o_busy && i_is_last,
                     r_state == S_LOAD, "permutation did not start")
    // The sixteen results come out back to back.
    `ARX_ASSERT_NEXT(a_burst, o_valid && !o_out_last, o_valid, "gap in result burst")
    // After the final result the block is free again.
    `ARX_ASSERT_NEXT(a_free, o_out_last, !o_busy, "still busy after last result")

endmodule
